>>> rtl/core/gsd_pkg.sv
`timescale 1ns / 1ps

package gsd_pkg;

  // Field widths of the channels and the configuration port
  localparam int OP_W       = 2;
  localparam int COORD_W    = 8;
  localparam int WORD_W     = 16;
  localparam int DIM_REG_W  = 9;
  localparam int RADIUS_W   = 8;
  localparam int MASK_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Operation codes
  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_RUN   = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLEARANCE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CLASS_MASK  = 2'd3;

  // Result kinds
  localparam logic RK_DONE = 1'b0;
  localparam logic RK_READ = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ_OUT,
    ST_RUN_START,
    ST_H_STEP,
    ST_H_WAIT,
    ST_V_STEP,
    ST_V_WAIT,
    ST_V_MERGE,
    ST_DONE_OUT
  } gsd_state_t;

  typedef struct packed {
    logic in_ready;
    logic host_wr;
    logic host_rd;
    logic ld_rd_out;
    logic ld_done_out;
    logic run_init;
    logic pass_v_init;
    logic line_next;
    logic scan_rd;
    logic scan_upd;
    logic emit;
    logic merge_rd;
    logic merge_wr;
    logic vert;
  } gsd_cmd_t;

  typedef struct packed {
    logic out_free;
    logic dims_zero;
    logic o_done;
    logic can_read;
    logic flag;
    logic last_line;
  } gsd_sts_t;

endpackage

>>> rtl/core/gsd_if.sv
`timescale 1ns / 1ps

interface gsd_req_if;
  import gsd_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [OP_W-1:0]       operation;
  logic [COORD_W-1:0]    cell_x;
  logic [COORD_W-1:0]    cell_y;
  logic [WORD_W-1:0]     cell_word;

  modport source (output valid, operation, cell_x, cell_y, cell_word, input ready);
  modport sink   (input valid, operation, cell_x, cell_y, cell_word, output ready);
endinterface

interface gsd_rsp_if;
  import gsd_pkg::*;

  logic              valid;
  logic              ready;
  logic              result_kind;
  logic [WORD_W-1:0] read_word;

  modport source (output valid, result_kind, read_word, input ready);
  modport sink   (input valid, result_kind, read_word, output ready);
endinterface

>>> rtl/core/gsd_ram.sv
`timescale 1ns / 1ps

module gsd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // rdata holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/gsd_ctrl.sv
`timescale 1ns / 1ps

module gsd_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic [gsd_pkg::OP_W-1:0] in_op,
  input  gsd_pkg::gsd_sts_t        sts,
  output gsd_pkg::gsd_cmd_t        cmd
);
  import gsd_pkg::*;

  gsd_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_op)
            OP_WRITE: begin
              cmd.host_wr = 1'b1;
            end
            OP_RUN: begin
              state_next = ST_RUN_START;
            end
            OP_READ: begin
              cmd.host_rd = 1'b1;
              state_next  = ST_READ_OUT;
            end
            default: begin
              // unused code: dropped
            end
          endcase
        end
      end
      ST_READ_OUT: begin
        if (sts.out_free) begin
          cmd.ld_rd_out = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      ST_RUN_START: begin
        if (sts.dims_zero) begin
          state_next = ST_DONE_OUT;
        end else begin
          cmd.run_init = 1'b1;
          state_next   = ST_H_STEP;
        end
      end
      ST_H_STEP: begin
        priority if (sts.o_done) begin
          if (sts.last_line) begin
            cmd.pass_v_init = 1'b1;
            state_next      = ST_V_STEP;
          end else begin
            cmd.line_next = 1'b1;
          end
        end else if (sts.can_read) begin
          cmd.scan_rd = 1'b1;
          state_next  = ST_H_WAIT;
        end else begin
          cmd.emit = 1'b1;
        end
      end
      ST_H_WAIT: begin
        cmd.scan_upd = 1'b1;
        state_next   = ST_H_STEP;
      end
      ST_V_STEP: begin
        cmd.vert = 1'b1;
        priority if (sts.o_done) begin
          if (sts.last_line) begin
            state_next = ST_DONE_OUT;
          end else begin
            cmd.line_next = 1'b1;
          end
        end else if (sts.can_read) begin
          cmd.scan_rd = 1'b1;
          state_next  = ST_V_WAIT;
        end else if (sts.flag) begin
          cmd.merge_rd = 1'b1;
          state_next   = ST_V_MERGE;
        end else begin
          cmd.emit = 1'b1;
        end
      end
      ST_V_WAIT: begin
        cmd.vert     = 1'b1;
        cmd.scan_upd = 1'b1;
        state_next   = ST_V_STEP;
      end
      ST_V_MERGE: begin
        cmd.vert     = 1'b1;
        cmd.merge_wr = 1'b1;
        state_next   = ST_V_STEP;
      end
      ST_DONE_OUT: begin
        if (sts.out_free) begin
          cmd.ld_done_out = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/gsd_datapath.sv
`timescale 1ns / 1ps

module gsd_datapath #(
  parameter int MAX_DIM   = 256,
  parameter int CELL_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  gsd_pkg::gsd_cmd_t              cmd,
  output gsd_pkg::gsd_sts_t              sts,
  input  logic [gsd_pkg::COORD_W-1:0]    cell_x,
  input  logic [gsd_pkg::COORD_W-1:0]    cell_y,
  input  logic [gsd_pkg::WORD_W-1:0]     cell_word,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic                           result_kind,
  output logic [gsd_pkg::WORD_W-1:0]     read_word,
  input  logic                           cfg_we,
  input  logic [gsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gsd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import gsd_pkg::*;

  localparam int XW    = $clog2(MAX_DIM);
  localparam int CW    = $clog2(MAX_DIM + 1);
  localparam int CELLS = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(CELLS);
  localparam int SW    = ((CW > RADIUS_W) ? CW : RADIUS_W) + 1;

  // configuration
  logic [DIM_REG_W-1:0] grid_width;
  logic [DIM_REG_W-1:0] grid_height;
  logic [RADIUS_W-1:0]  clearance;
  logic [MASK_W-1:0]    class_mask;

  // scan state
  logic [XW-1:0] ln;
  logic [CW-1:0] k;
  logic [CW-1:0] o;
  logic [XW-1:0] lb;
  logic          hv;
  logic          rd_inside;

  logic [CW-1:0]        w_c, h_c, n, lines, idx;
  logic [XW-1:0]        run_x, run_y, host_x, host_y;
  logic [AW-1:0]        run_addr, host_addr;
  logic                 host_inside;
  logic [CELL_BITS-1:0] cell_rdata, mask_c;
  logic                 scr_rdata;
  logic                 blocked_bit;
  logic                 flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= DIM_REG_W'(256);
      grid_height <= DIM_REG_W'(256);
      clearance   <= RADIUS_W'(1);
      class_mask  <= MASK_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GRID_WIDTH:  grid_width  <= cfg_data[DIM_REG_W-1:0];
        CFG_GRID_HEIGHT: grid_height <= cfg_data[DIM_REG_W-1:0];
        CFG_CLEARANCE:   clearance   <= cfg_data[RADIUS_W-1:0];
        CFG_CLASS_MASK:  class_mask  <= cfg_data[MASK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // sizes above MAX_DIM saturate
  assign w_c = (32'(grid_width)  > MAX_DIM) ? CW'(MAX_DIM) : CW'(grid_width);
  assign h_c = (32'(grid_height) > MAX_DIM) ? CW'(MAX_DIM) : CW'(grid_height);

  assign n     = cmd.vert ? h_c : w_c;
  assign lines = cmd.vert ? w_c : h_c;
  assign idx   = cmd.scan_rd ? k : o;

  // horizontal pass walks rows, vertical pass walks columns
  assign run_x    = cmd.vert ? ln : idx[XW-1:0];
  assign run_y    = cmd.vert ? idx[XW-1:0] : ln;
  assign run_addr = AW'(run_y) * AW'(MAX_DIM) + AW'(run_x);

  assign host_inside = (32'(cell_x) < MAX_DIM) && (32'(cell_y) < MAX_DIM);
  assign host_x      = XW'(cell_x);
  assign host_y      = XW'(cell_y);
  assign host_addr   = AW'(host_y) * AW'(MAX_DIM) + AW'(host_x);

  assign mask_c      = CELL_BITS'(class_mask);
  assign blocked_bit = cmd.vert ? scr_rdata : (|(cell_rdata & mask_c));

  // a blocked cell within clearance of o exists iff the latest one seen is close enough
  assign flag = hv && ((SW'(lb) + SW'(clearance)) >= SW'(o));

  assign sts.out_free  = !out_valid || out_ready;
  assign sts.dims_zero = (grid_width == '0) || (grid_height == '0);
  assign sts.o_done    = (o == n);
  assign sts.can_read  = (k < n) && (SW'(k) <= (SW'(o) + SW'(clearance)));
  assign sts.flag      = flag;
  assign sts.last_line = (CW'(ln) == (lines - CW'(1)));

  always_ff @(posedge clk) begin
    if (cmd.run_init || cmd.pass_v_init) begin
      ln <= '0;
      k  <= '0;
      o  <= '0;
      hv <= 1'b0;
    end else if (cmd.line_next) begin
      ln <= ln + XW'(1);
      k  <= '0;
      o  <= '0;
      hv <= 1'b0;
    end else begin
      if (cmd.scan_upd) begin
        if (blocked_bit) begin
          lb <= k[XW-1:0];
          hv <= 1'b1;
        end
        k <= k + CW'(1);
      end
      if (cmd.emit || cmd.merge_wr) begin
        o <= o + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.host_rd) begin
      rd_inside <= host_inside;
    end
  end

  gsd_ram #(
    .WIDTH (CELL_BITS),
    .DEPTH (CELLS)
  ) u_cell_ram (
    .clk   (clk),
    .we    ((cmd.host_wr && host_inside) || cmd.merge_wr),
    .waddr (cmd.host_wr ? host_addr : run_addr),
    .wdata (cmd.host_wr ? CELL_BITS'(cell_word) : (cell_rdata | mask_c)),
    .re    ((cmd.host_rd && host_inside) || (cmd.scan_rd && !cmd.vert) || cmd.merge_rd),
    .raddr (cmd.host_rd ? host_addr : run_addr),
    .rdata (cell_rdata)
  );

  gsd_ram #(
    .WIDTH (1),
    .DEPTH (CELLS)
  ) u_scratch_ram (
    .clk   (clk),
    .we    (cmd.emit && !cmd.vert),
    .waddr (run_addr),
    .wdata (flag),
    .re    (cmd.scan_rd && cmd.vert),
    .raddr (run_addr),
    .rdata (scr_rdata)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.ld_rd_out || cmd.ld_done_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_rd_out) begin
      result_kind <= RK_READ;
      read_word   <= rd_inside ? WORD_W'(cell_rdata) : '0;
    end else if (cmd.ld_done_out) begin
      result_kind <= RK_DONE;
      read_word   <= '0;
    end
  end

endmodule

>>> rtl/core/grid_square_dilation.sv
`timescale 1ns / 1ps

// Channel  Dir  Fields                                     Transfer
// req      in   operation, cell_x, cell_y, cell_word       valid && ready
// rsp      out  result_kind, read_word                     valid && ready
// cfg      in   cfg_index, cfg_data                        cfg_we
//
// Write: no result. Read: the cell is read from its grid memory, then loaded into
// the output register once that register is free. Run: a horizontal pass over
// the rows, then a vertical pass over the columns; each grid memory has a
// single registered read port.
// Reset is synchronous; the grid memories are not cleared and need no sweep.
// A pending result does not block writes; a read or run waits until it is taken.

module grid_square_dilation #(
  parameter int MAX_DIM   = 256,
  parameter int CELL_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  gsd_req_if.sink                        req,
  gsd_rsp_if.source                      rsp,
  input  logic                           cfg_we,
  input  logic [gsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gsd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import gsd_pkg::*;

  gsd_cmd_t cmd;
  gsd_sts_t sts;

  // the controller owns req.ready; items are taken only in idle
  assign req.ready = cmd.in_ready;

  gsd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_op    (req.operation),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath holds the config registers, scan counters, both grid memories
  // and the result register
  gsd_datapath #(
    .MAX_DIM   (MAX_DIM),
    .CELL_BITS (CELL_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cell_x      (req.cell_x),
    .cell_y      (req.cell_y),
    .cell_word   (req.cell_word),
    .out_ready   (rsp.ready),
    .out_valid   (rsp.valid),
    .result_kind (rsp.result_kind),
    .read_word   (rsp.read_word),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

endmodule

>>> tb/sv/grid_square_dilation_test.sv
`timescale 1ns / 1ps

typedef struct packed {
  logic        kind;
  logic [15:0] word;
} grid_result_t;

// Mirror of the cell grid and the four registers; holds the results still owed by the block.
class grid_mirror;
  logic [15:0]  cell_mem [0:65535];
  int unsigned  width_reg;
  int unsigned  height_reg;
  int unsigned  radius_reg;
  logic [15:0]  mask_reg;
  grid_result_t owed_results [$];
  int unsigned  mismatches;

  function new();
    width_reg   = 256;
    height_reg  = 256;
    radius_reg  = 1;
    mask_reg    = 16'h0001;
    mismatches  = 0;
  endfunction

  function void set_reg(input logic [1:0] idx, input logic [15:0] data);
    case (idx)
      gsd_pkg::CFG_GRID_WIDTH:  width_reg  = 32'(data[8:0]);
      gsd_pkg::CFG_GRID_HEIGHT: height_reg = 32'(data[8:0]);
      gsd_pkg::CFG_CLEARANCE:   radius_reg = 32'(data[7:0]);
      gsd_pkg::CFG_CLASS_MASK:  mask_reg   = data;
      default: ;
    endcase
  endfunction

  // Square dilation through prefix sums: rows into a 1-bit mark grid, then columns.
  function void dilate_region();
    int w, h, r, lo, hi;
    bit hmark [];
    int acc [];
    w = (width_reg > 256) ? 256 : int'(width_reg);
    h = (height_reg > 256) ? 256 : int'(height_reg);
    r = int'(radius_reg);
    if (w == 0 || h == 0) return;
    hmark = new[w * h];
    acc = new[((w > h) ? w : h) + 1];
    for (int j = 0; j < h; j++) begin
      acc[0] = 0;
      for (int i = 0; i < w; i++)
        acc[i + 1] = acc[i] + (((cell_mem[j * 256 + i] & mask_reg) != 16'h0) ? 1 : 0);
      for (int i = 0; i < w; i++) begin
        lo = (i > r) ? i - r : 0;
        hi = (i + r < w) ? i + r : w - 1;
        hmark[j * w + i] = (acc[hi + 1] - acc[lo]) != 0;
      end
    end
    for (int i = 0; i < w; i++) begin
      acc[0] = 0;
      for (int j = 0; j < h; j++)
        acc[j + 1] = acc[j] + (hmark[j * w + i] ? 1 : 0);
      for (int j = 0; j < h; j++) begin
        lo = (j > r) ? j - r : 0;
        hi = (j + r < h) ? j + r : h - 1;
        if (acc[hi + 1] - acc[lo] != 0)
          cell_mem[j * 256 + i] = cell_mem[j * 256 + i] | mask_reg;
      end
    end
  endfunction

  function void take_item(input logic [1:0] op, input logic [7:0] x, input logic [7:0] y,
                          input logic [15:0] word);
    grid_result_t res;
    case (op)
      gsd_pkg::OP_WRITE: cell_mem[{y, x}] = word;
      gsd_pkg::OP_RUN: begin
        dilate_region();
        res.kind = gsd_pkg::RK_DONE;
        res.word = 16'h0;
        owed_results = {owed_results, res};
      end
      gsd_pkg::OP_READ: begin
        res.kind = gsd_pkg::RK_READ;
        res.word = cell_mem[{y, x}];
        owed_results = {owed_results, res};
      end
      default: ;
    endcase
  endfunction

  function void match_result(input logic kind, input logic [15:0] word);
    grid_result_t want;
    if (owed_results.size() == 0) begin
      $error("unexpected result: result_kind %0d read_word %h", kind, word);
      mismatches++;
      return;
    end
    want = owed_results.pop_front();
    if (kind !== want.kind) begin
      $error("result_kind: expected %0d, actual %0d", want.kind, kind);
      mismatches++;
    end
    if (word !== want.word) begin
      $error("read_word: expected %h, actual %h", want.word, word);
      mismatches++;
    end
  endfunction

  function int owed();
    return owed_results.size();
  endfunction
endclass

module grid_square_dilation_test;
  import gsd_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;  // ignored code, used as noise
  localparam int GRID_DIM    = 256;
  localparam int ITEM_TARGET = 1250;
  localparam int HOLD_CYCLES = 300;               // long receiver hold-off
  localparam int DRAIN_WAIT  = 20;                // write/read latency margin before cfg writes

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  gsd_req_if req_ch ();
  gsd_rsp_if rsp_ch ();

  grid_square_dilation u_dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  grid_mirror mirror;

  // Stimulus-side view of the grid: which cells hold defined data, and the
  // effective (clamped) region size. Runs and reads only touch written cells.
  bit          written_map [0:GRID_DIM*GRID_DIM-1];
  int          written_list [$];
  int          cur_w, cur_h;
  logic [15:0] cur_mask;
  bit          quiet_tx;
  int          items_sent;
  int          hold_asks;   // bumped by stimulus, consumed by the response side
  int          hold_taken;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop; a correct run ends well before this.
  initial begin
    #(10_000_000);
    $display("FAIL");
    $finish;
  end

  // Response side: random ready with short and occasional long stalls, calm
  // stretches with ready held high, and the requested long hold-off.
  initial begin : rsp_side
    int stall_left;
    int calm_left;
    stall_left = 0;
    calm_left  = 0;
    hold_taken = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready)
        mirror.match_result(rsp_ch.result_kind, rsp_ch.read_word);
      if (hold_taken != hold_asks) begin
        hold_taken = hold_taken + 1;
        stall_left = HOLD_CYCLES;
      end
      if (calm_left > 0)
        calm_left--;
      else if ($urandom_range(0, 399) == 0)
        calm_left = $urandom_range(50, 200);
      if (stall_left == 0 && calm_left == 0 && $urandom_range(0, 99) < 20)
        stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  function automatic int pick_gap();
    int p;
    if (quiet_tx) return 0;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Cell word for a fill: about one in ten cells blocked under the current mask.
  function automatic logic [15:0] make_word();
    logic [15:0] w;
    w = 16'($urandom);
    if (cur_mask != 16'h0 && $urandom_range(0, 9) == 0) begin
      if ((w & cur_mask) == 16'h0) w = w | (cur_mask & (~cur_mask + 16'h1));
    end else begin
      w = w & ~cur_mask;
    end
    return w;
  endfunction

  // One request transfer. valid stays high on return so back-to-back items
  // need no extra edge; a gap or settle lowers it.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [7:0] x, input logic [7:0] y,
                           input logic [15:0] word);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.operation <= op;
    req_ch.cell_x    <= x;
    req_ch.cell_y    <= y;
    req_ch.cell_word <= word;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    mirror.take_item(op, x, y, word);
    if (op == OP_WRITE && !written_map[{y, x}]) begin
      written_map[{y, x}] = 1'b1;
      written_list = {written_list, int'({y, x})};
    end
    if (op != OP_UNUSED) items_sent++;
  endtask

  task automatic read_known();
    int a;
    a = written_list[$urandom_range(0, written_list.size() - 1)];
    send_item(OP_READ, a[7:0], a[15:8], 16'($urandom));
  endtask

  task automatic run_once();
    send_item(OP_RUN, 8'($urandom), 8'($urandom), 16'($urandom));
  endtask

  // Wait for every owed result, then let in-flight writes finish.
  task automatic settle();
    req_ch.valid <= 1'b0;
    while (mirror.owed() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    mirror.set_reg(idx, data);
  endtask

  // Register writes only while idle. Unused upper data bits carry noise.
  task automatic set_config(input int w, input int h, input int r, input logic [15:0] m);
    logic [15:0] d;
    settle();
    d = 16'($urandom); d[8:0] = w[8:0];
    write_reg(CFG_GRID_WIDTH, d);
    d = 16'($urandom); d[8:0] = h[8:0];
    write_reg(CFG_GRID_HEIGHT, d);
    d = 16'($urandom); d[7:0] = r[7:0];
    write_reg(CFG_CLEARANCE, d);
    write_reg(CFG_CLASS_MASK, m);
    cfg_we <= 1'b0;
    cur_w    = (w[8:0] > GRID_DIM) ? GRID_DIM : w[8:0];
    cur_h    = (h[8:0] > GRID_DIM) ? GRID_DIM : h[8:0];
    cur_mask = m;
  endtask

  // Rewrite the whole in-use region so a run never sees undefined cells.
  task automatic fill_region();
    for (int j = 0; j < cur_h; j++)
      for (int i = 0; i < cur_w; i++)
        send_item(OP_WRITE, i[7:0], j[7:0], make_word());
  endtask

  task automatic random_phase(input bit squeeze);
    int w, h, r, p, n;
    logic [15:0] m;
    logic [7:0] x, y;
    w = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 8) : $urandom_range(9, 16);
    h = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 8) : $urandom_range(9, 16);
    p = $urandom_range(0, 99);
    if (p < 50)      r = $urandom_range(0, 2);
    else if (p < 80) r = $urandom_range(3, 8);
    else if (p < 90) r = 255;
    else             r = $urandom_range(0, 255);
    p = $urandom_range(0, 99);
    if (p < 15)      m = 16'hFFFF;
    else if (p < 25) m = 16'h0000;
    else if (p < 60) m = 16'h0001 << $urandom_range(0, 15);
    else             m = 16'($urandom);
    set_config(w, h, r, m);
    quiet_tx = ($urandom_range(0, 3) == 0);
    fill_region();
    if (squeeze) begin
      // Long receiver hold-off while reads keep coming: the output fills
      // and the request side has to stall.
      quiet_tx  = 1'b1;
      hold_asks = hold_asks + 1;
      repeat (30) read_known();
      quiet_tx  = 1'b0;
    end
    n = $urandom_range(30, 50);
    repeat (n) begin
      p = $urandom_range(0, 99);
      if (p < 35) begin
        if ($urandom_range(0, 9) < 7) begin
          x = 8'($urandom_range(0, cur_w - 1));
          y = 8'($urandom_range(0, cur_h - 1));
        end else begin
          x = 8'($urandom);
          y = 8'($urandom);
        end
        send_item(OP_WRITE, x, y, make_word());
      end else if (p < 70) begin
        read_known();
      end else if (p < 82) begin
        run_once();
      end else if (p < 90) begin
        send_item(OP_UNUSED, 8'($urandom), 8'($urandom), 16'($urandom));
      end else begin
        // read right behind a write to the same cell
        x = 8'($urandom);
        y = 8'($urandom);
        send_item(OP_WRITE, x, y, 16'($urandom));
        send_item(OP_READ, x, y, 16'($urandom));
      end
    end
  endtask

  initial begin : stimulus
    int phase_no;
    mirror     = new();
    quiet_tx   = 1'b0;
    items_sent = 0;
    hold_asks  = 0;
    cur_w      = GRID_DIM;
    cur_h      = GRID_DIM;
    cur_mask   = 16'h0001;
    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_index        <= '0;
    cfg_data         <= '0;
    req_ch.valid     <= 1'b0;
    req_ch.operation <= '0;
    req_ch.cell_x    <= '0;
    req_ch.cell_y    <= '0;
    req_ch.cell_word <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Corner cells, all-ones and all-zero words, overwrite, and the unused
    // code, which must leave the grid alone.
    send_item(OP_WRITE, 8'd0, 8'd0, 16'hFFFF);
    send_item(OP_WRITE, 8'd255, 8'd255, 16'hFFFF);
    send_item(OP_WRITE, 8'd255, 8'd0, 16'h0001);
    send_item(OP_WRITE, 8'd0, 8'd255, 16'h8000);
    send_item(OP_WRITE, 8'd0, 8'd0, 16'h0000);
    send_item(OP_UNUSED, 8'd0, 8'd0, 16'hFFFF);
    send_item(OP_READ, 8'd0, 8'd0, 16'h0);
    send_item(OP_READ, 8'd255, 8'd255, 16'h0);
    send_item(OP_READ, 8'd255, 8'd0, 16'h0);
    send_item(OP_READ, 8'd0, 8'd255, 16'h0);
    send_item(OP_UNUSED, 8'd255, 8'd255, 16'h0000);
    send_item(OP_READ, 8'd255, 8'd255, 16'h0);

    // Zero width, then zero height: the run touches nothing but still reports done.
    set_config(0, 256, 1, 16'h0001);
    run_once();
    set_config(256, 0, 1, 16'h0001);
    run_once();
    send_item(OP_READ, 8'd0, 8'd255, 16'h0);

    // Small hand-made grid: one blocked cell in a corner, radius one.
    set_config(3, 2, 1, 16'h0001);
    send_item(OP_WRITE, 8'd0, 8'd0, 16'h0010);
    send_item(OP_WRITE, 8'd1, 8'd0, 16'h0000);
    send_item(OP_WRITE, 8'd2, 8'd0, 16'h0100);
    send_item(OP_WRITE, 8'd0, 8'd1, 16'h0000);
    send_item(OP_WRITE, 8'd1, 8'd1, 16'h0000);
    send_item(OP_WRITE, 8'd2, 8'd1, 16'h0001);
    run_once();
    send_item(OP_READ, 8'd0, 8'd0, 16'h0);
    send_item(OP_READ, 8'd1, 8'd0, 16'h0);
    send_item(OP_READ, 8'd2, 8'd0, 16'h0);
    send_item(OP_READ, 8'd0, 8'd1, 16'h0);

    // Oversized width saturates to a full row; full-height single column
    // with the largest radius.
    set_config(511, 1, 3, 16'h0004);
    fill_region();
    run_once();
    repeat (6) read_known();
    set_config(1, 256, 255, 16'h8001);
    fill_region();
    run_once();
    repeat (6) read_known();

    phase_no = 0;
    while (items_sent < ITEM_TARGET) begin
      random_phase(phase_no % 7 == 0);
      phase_no++;
    end

    settle();
    repeat (50) @(posedge clk);
    if (mirror.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/gsd_pkg.sv
rtl/core/gsd_if.sv
rtl/core/gsd_ram.sv
rtl/core/gsd_ctrl.sv
rtl/core/gsd_datapath.sv
rtl/core/grid_square_dilation.sv
tb/sv/grid_square_dilation_test.sv
